// ----- rtl/mtpm_pkg.sv -----
// Shared types and constants of the multitrack pan mixer.
package mtpm_pkg;

  localparam int SETTING_REGS = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_W        = 52;
  localparam int COUNT_W      = 17;
  localparam int PH_W         = 31;

  // Output frame rate, split into a power of two and an odd part.
  localparam int OUT_RATE   = 48000;
  localparam int RATE_SHIFT = 7;
  localparam int RATE_ODD   = OUT_RATE >> RATE_SHIFT;
  localparam logic [23:0] RATE_RECIP = 24'((64'd1 << 32) / RATE_ODD);

  localparam int END_MARGIN = 100;
  localparam logic [15:0] MASTER_RESET = 16'd16384;
  localparam logic [16:0] VOL_MAX = 17'd32768;

  localparam logic [CFG_IDX_W-1:0] CFG_MASTER = 3'd0;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_RENDER = 3'd1,
    CMD_SEEK   = 3'd2,
    CMD_PLAY   = 3'd3,
    CMD_PAUSE  = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RECIP,
    ST_CORR,
    ST_RD0,
    ST_RD1,
    ST_MULV,
    ST_MULG,
    ST_ACC,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [1:0]         track;
    logic [15:0]        sample_index;
    logic signed [15:0] sample_value;
    logic               last_sample;
    logic [30:0]        seek_frame;
  } mtpm_in_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               playing;
    logic               any_track_active;
  } mtpm_out_t;

endpackage

// ----- rtl/multitrack_pan_mixer.sv -----
// Stereo mixer over stored PCM tracks with volume, linear pan and master gain.
// Samples are loaded into one sample memory with a write port for loads and a
// registered read port (one read per cycle), and each render transfer produces
// one stereo frame. Load, seek, play, pause and clear are taken in the idle
// state and do not start the sequencer. While playing, a render is walked
// through the tracks one at a time by a sequencer: a disabled or muted track
// only passes the setup state, an enabled track past its end also passes the
// reciprocal, correction and first read states (playhead times rate, then
// division by the output rate as reciprocal multiply and correction), and a
// track in range goes on through its second memory read, the two multiplier
// stages and the accumulate state. The closing states FIN1 to FIN3 for rounding
// and master gain follow, then a hand-off state that waits on a stalled output;
// while paused, a render goes straight to the hand-off state. The input is not
// taken while a frame is being mixed; a finished result may wait in the output
// register while the next commands are accepted.
module multitrack_pan_mixer #(
  parameter int NUM_TRACKS    = 4,
  parameter int TRACK_SAMPLES = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mtpm_pkg::mtpm_in_t                 in_payload,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mtpm_pkg::mtpm_out_t                out_payload,
  input  logic                               cfg_we,
  input  logic [mtpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mtpm_pkg::CFG_W-1:0]         cfg_wdata
);
  import mtpm_pkg::*;

  localparam int AW         = $clog2(TRACK_SAMPLES);
  localparam int TW         = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
  localparam int MEM_DEPTH  = NUM_TRACKS * (2 ** AW);
  localparam int MIX_TRACKS = (NUM_TRACKS < SETTING_REGS) ? NUM_TRACKS : SETTING_REGS;
  localparam logic [TW-1:0] LAST_TRK = TW'(MIX_TRACKS - 1);

  // Storage.
  logic [15:0]         sample_mem [MEM_DEPTH];
  logic [15:0]         rdata_r;
  logic [COUNT_W-1:0]  counts_r [NUM_TRACKS];
  logic [CFG_W-1:0]    settings_r [SETTING_REGS];
  logic [15:0]         master_r;
  logic [PH_W-1:0]     ph_r;
  logic                play_r;

  // Sequencer and datapath.
  state_t              state_r, state_nxt;
  logic [TW-1:0]       trk_r;
  logic [47:0]         prod_r;
  logic                big_r;
  logic [24:0]         x_r;
  logic [16:0]         qm_r;
  logic [16:0]         tf_r;
  logic [16:0]         frames_r;
  logic                stereo_r;
  logic [16:0]         vol_r;
  logic signed [15:0]  pan_r;
  logic signed [15:0]  sl_r;
  logic signed [32:0]  pl_r, pr_r;
  logic signed [51:0]  tl_r, tr_r;
  logic signed [51:0]  accl_r, accr_r;
  logic signed [35:0]  al_r, ar_r;
  logic signed [52:0]  ml_r, mr_r;
  logic                active_r;
  mtpm_out_t           res_r;
  logic                out_valid_r;
  mtpm_out_t           out_payload_r;

  logic                fire;
  logic                load_ok;
  logic                any_loaded;
  logic                last_trk;
  logic                trk_on;
  logic                trk_in_range;
  logic                out_slot;

  logic [CFG_W-1:0]    cur_set;
  logic [16:0]         cur_vol;
  logic [16:0]         cur_rate;
  logic [16:0]         cur_count;

  logic [48:0]         qprod;
  logic [25:0]         q375;
  logic [25:0]         rem;
  logic [16:0]         tf_c;

  logic [17:0]         rd_off;
  logic [TW+AW-1:0]    rd_addr;
  logic [TW+AW-1:0]    wr_addr;

  logic signed [32:0]  sl_x, sr_x, vol_x;
  logic signed [17:0]  pan_x, gl_c, gr_c;
  logic signed [51:0]  pl_x, pr_x, gl_x, gr_x;
  logic signed [51:0]  accl_rnd, accr_rnd;
  logic signed [52:0]  al_x, ar_x, m_x;
  logic signed [52:0]  ml_rnd, mr_rnd;
  logic signed [23:0]  vl, vr;
  logic signed [15:0]  sat_l, sat_r;
  logic [PH_W-1:0]     ph_inc;
  logic                frame_end;

  assign fire     = in_valid && !in_stall;
  assign out_slot = !out_valid_r || !out_stall;
  assign load_ok  = (32'(in_payload.track) < 32'(NUM_TRACKS)) &&
                    (32'(in_payload.sample_index) < 32'(TRACK_SAMPLES));
  assign last_trk = (trk_r == LAST_TRK);

  always_comb begin
    any_loaded = 1'b0;
    for (int i = 0; i < NUM_TRACKS; i++) begin
      any_loaded = any_loaded | (counts_r[i] != '0);
    end
  end

  // Current track settings.
  assign cur_set   = settings_r[2'(trk_r)];
  assign cur_vol   = {1'b0, cur_set[18:3]};
  assign cur_rate  = cur_set[51:35];
  assign cur_count = counts_r[trk_r];
  assign trk_on    = cur_set[0] && !cur_set[1];

  // Frame index: floor(P / 128) / 375 through a reciprocal and one correction.
  assign qprod = 49'(prod_r[31:7]) * 49'(RATE_RECIP);
  assign q375  = 26'(qm_r) * 26'(RATE_ODD);
  assign rem   = {1'b0, x_r} - q375;
  assign tf_c  = (rem >= 26'(RATE_ODD)) ? qm_r + 17'd1 : qm_r;
  assign trk_in_range = !big_r && (tf_r < frames_r);

  // Sample memory addresses.
  always_comb begin
    if (state_r == ST_RD1) begin
      rd_off = {tf_r, 1'b1};
    end else if (stereo_r) begin
      rd_off = {tf_r, 1'b0};
    end else begin
      rd_off = {1'b0, tf_r};
    end
  end
  assign rd_addr = {trk_r, AW'(rd_off)};
  assign wr_addr = {TW'(in_payload.track), AW'(in_payload.sample_index)};

  // Gain arithmetic.
  assign sl_x  = 33'(sl_r);
  assign sr_x  = stereo_r ? 33'($signed(rdata_r)) : 33'(sl_r);
  assign vol_x = {16'd0, vol_r};
  assign pan_x = 18'(pan_r);
  assign gl_c  = 18'sd32768 - pan_x;
  assign gr_c  = 18'sd32768 + pan_x;
  assign pl_x  = 52'(pl_r);
  assign pr_x  = 52'(pr_r);
  assign gl_x  = 52'(gl_c);
  assign gr_x  = 52'(gr_c);

  assign accl_rnd = accl_r + 52'sd32768;
  assign accr_rnd = accr_r + 52'sd32768;
  assign al_x     = 53'(al_r);
  assign ar_x     = 53'(ar_r);
  assign m_x      = {37'd0, master_r};
  assign ml_rnd   = ml_r + 53'sd268435456;
  assign mr_rnd   = mr_r + 53'sd268435456;
  assign vl       = ml_rnd[52:29];
  assign vr       = mr_rnd[52:29];

  always_comb begin
    if (vl > 24'sd32767) begin
      sat_l = 16'sh7FFF;
    end else if (vl < -24'sd32768) begin
      sat_l = 16'sh8000;
    end else begin
      sat_l = vl[15:0];
    end
    if (vr > 24'sd32767) begin
      sat_r = 16'sh7FFF;
    end else if (vr < -24'sd32768) begin
      sat_r = 16'sh8000;
    end else begin
      sat_r = vr[15:0];
    end
  end

  // The playhead advances first; the end-of-material check uses the new value.
  assign ph_inc    = (ph_r == '1) ? ph_r : ph_r + 1'b1;
  assign frame_end = !active_r && any_loaded && (ph_inc > PH_W'(END_MARGIN));

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_payload.command == CMD_RENDER) begin
          state_nxt = play_r ? ST_SETUP : ST_OUT;
        end
      end
      ST_SETUP: begin
        if (trk_on) begin
          state_nxt = ST_RECIP;
        end else if (last_trk) begin
          state_nxt = ST_FIN1;
        end
      end
      ST_RECIP: state_nxt = ST_CORR;
      ST_CORR:  state_nxt = ST_RD0;
      ST_RD0: begin
        if (trk_in_range) begin
          state_nxt = ST_RD1;
        end else begin
          state_nxt = last_trk ? ST_FIN1 : ST_SETUP;
        end
      end
      ST_RD1:  state_nxt = ST_MULV;
      ST_MULV: state_nxt = ST_MULG;
      ST_MULG: state_nxt = ST_ACC;
      ST_ACC:  state_nxt = last_trk ? ST_FIN1 : ST_SETUP;
      ST_FIN1: state_nxt = ST_FIN2;
      ST_FIN2: state_nxt = ST_FIN3;
      ST_FIN3: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_slot) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sample memory: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (fire && in_payload.command == CMD_LOAD && load_ok) begin
      sample_mem[wr_addr] <= in_payload.sample_value;
    end
    rdata_r <= sample_mem[rd_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= MASTER_RESET;
      for (int i = 0; i < SETTING_REGS; i++) begin
        settings_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_MASTER) begin
        master_r <= cfg_wdata[15:0];
      end else if (32'(cfg_index) <= 32'(SETTING_REGS)) begin
        settings_r[2'(cfg_index - 1'b1)] <= cfg_wdata;
      end
    end
  end

  // Transport state and track lengths.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= '0;
      play_r <= 1'b0;
      for (int i = 0; i < NUM_TRACKS; i++) begin
        counts_r[i] <= '0;
      end
    end else if (fire) begin
      case (in_payload.command)
        CMD_LOAD: begin
          if (load_ok && in_payload.last_sample) begin
            counts_r[TW'(in_payload.track)] <= COUNT_W'(in_payload.sample_index) + 1'b1;
          end
        end
        CMD_SEEK:  ph_r   <= in_payload.seek_frame;
        CMD_PLAY:  play_r <= 1'b1;
        CMD_PAUSE: play_r <= 1'b0;
        CMD_CLEAR: begin
          ph_r <= '0;
          for (int i = 0; i < NUM_TRACKS; i++) begin
            counts_r[i] <= '0;
          end
        end
        default: ;
      endcase
    end else if (state_r == ST_FIN3) begin
      ph_r <= frame_end ? '0 : ph_inc;
      if (frame_end) begin
        play_r <= 1'b0;
      end
    end
  end

  // Mixing datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        trk_r    <= '0;
        accl_r   <= '0;
        accr_r   <= '0;
        active_r <= 1'b0;
        res_r    <= '0;
      end
      ST_SETUP: begin
        prod_r   <= 48'(ph_r) * 48'(cur_rate);
        stereo_r <= cur_set[2];
        vol_r    <= (cur_vol > VOL_MAX) ? VOL_MAX : cur_vol;
        pan_r    <= cur_set[34:19];
        frames_r <= cur_set[2] ? (cur_count >> 1) : cur_count;
        if (!trk_on && !last_trk) begin
          trk_r <= trk_r + 1'b1;
        end
      end
      ST_RECIP: begin
        big_r <= (prod_r[47:32] != '0);
        x_r   <= prod_r[31:7];
        qm_r  <= qprod[48:32];
      end
      ST_CORR: tf_r <= tf_c;
      ST_RD0: begin
        if (trk_in_range) begin
          active_r <= 1'b1;
        end else if (!last_trk) begin
          trk_r <= trk_r + 1'b1;
        end
      end
      ST_RD1: sl_r <= rdata_r;
      ST_MULV: begin
        pl_r <= sl_x * vol_x;
        pr_r <= sr_x * vol_x;
      end
      ST_MULG: begin
        tl_r <= pl_x * gl_x;
        tr_r <= pr_x * gr_x;
      end
      ST_ACC: begin
        accl_r <= accl_r + tl_r;
        accr_r <= accr_r + tr_r;
        if (!last_trk) begin
          trk_r <= trk_r + 1'b1;
        end
      end
      ST_FIN1: begin
        al_r <= accl_rnd[51:16];
        ar_r <= accr_rnd[51:16];
      end
      ST_FIN2: begin
        ml_r <= al_x * m_x;
        mr_r <= ar_x * m_x;
      end
      ST_FIN3: begin
        res_r.left_sample      <= sat_l;
        res_r.right_sample     <= sat_r;
        res_r.playing          <= !frame_end;
        res_r.any_track_active <= active_r;
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_slot) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_slot) begin
      out_payload_r <= res_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  // A transfer of any command other than render never starts the sequencer.
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_payload.command != CMD_RENDER) |=> state_r == ST_IDLE)
    else $error("non-render command left the idle state");

  // A render transfer always moves the sequencer out of the idle state.
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_payload.command == CMD_RENDER) |=> state_r != ST_IDLE)
    else $error("render transfer did not start a frame");

  // The track counter never walks past the last mixed track.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_OUT) |-> trk_r <= LAST_TRK)
    else $error("track counter out of range");

  // A new result only appears from the hand-off state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result shown outside the hand-off state");

  // Play stops only through pause, the end-of-material check or reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(play_r) |-> (!$past(rst_n) || $past(state_r == ST_FIN3) ||
                       $past(fire && in_payload.command == CMD_PAUSE)))
    else $error("play flag cleared unexpectedly");

endmodule

// ----- bench/multitrack_pan_mixer_tb.sv -----
// Self-checking testbench of the multitrack pan mixer: directed cases, then a randomized mix.
`timescale 1ns / 1ps

module multitrack_pan_mixer_tb;
  import mtpm_pkg::*;

  localparam logic [2:0]  CMD_RSVD_LO   = 3'd6;
  localparam logic [2:0]  CMD_RSVD_HI   = 3'd7;
  localparam int          TRACKS        = 4;
  localparam int          MEM_DEPTH     = 65536;
  localparam int          ITEM_GOAL     = 900;
  localparam int          SETTLE_CYCLES = 60;
  localparam logic [30:0] PH_LIMIT      = 31'h7FFF_FFFF;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  mtpm_in_t             in_payload;
  logic                 out_valid;
  logic                 out_stall;
  mtpm_out_t            out_payload;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Mixer state as the bench predicts it.
  logic [15:0]          mix_master;
  logic [CFG_W-1:0]     mix_track_cfg [TRACKS];
  logic signed [15:0]   pcm_store [TRACKS][MEM_DEPTH];
  logic [COUNT_W-1:0]   pcm_count [TRACKS];
  logic [PH_W-1:0]      playhead;
  logic                 playing_now;
  mtpm_out_t            frames_due [$];

  // Which sample slots hold data, and how far each track is loaded without holes.
  bit                   pcm_written [TRACKS][MEM_DEPTH];
  int                   pcm_prefix [TRACKS];

  logic [15:0]          next_master;
  logic [CFG_W-1:0]     next_track_cfg [TRACKS];

  int items_sent     = 0;
  int frames_checked = 0;
  int mismatches     = 0;
  int stops_seen     = 0;
  int clipped_frames = 0;
  int calm_left      = 0;
  int stall_left     = 0;

  multitrack_pan_mixer dut (.*);

  always #10 clk = ~clk;

  function automatic longint round_q(input longint x, input int sh);
    return (x + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [CFG_W-1:0] pack_track(input bit en, input bit mute,
      input bit stereo, input logic [15:0] vol, input logic [15:0] pan,
      input logic [16:0] rate);
    return {rate, pan, vol, stereo, mute, en};
  endfunction

  function automatic void predict(input mtpm_in_t it);
    mtpm_out_t             fr;
    longint                acc_l, acc_r, ml, mr, sl, sr, vol, pan, mg;
    longint unsigned       frames, tf, rate;
    logic [CFG_W-1:0]      s;
    bit                    active, loaded;
    case (it.command)
      CMD_LOAD: begin
        pcm_store[it.track][it.sample_index] = it.sample_value;
        if (it.last_sample) pcm_count[it.track] = {1'b0, it.sample_index} + 17'd1;
      end
      CMD_SEEK:  playhead = it.seek_frame;
      CMD_PLAY:  playing_now = 1'b1;
      CMD_PAUSE: playing_now = 1'b0;
      CMD_CLEAR: begin
        foreach (pcm_count[t]) pcm_count[t] = '0;
        playhead = '0;
      end
      CMD_RENDER: begin
        fr = '0;
        if (playing_now) begin
          acc_l  = 0;
          acc_r  = 0;
          active = 1'b0;
          loaded = 1'b0;
          for (int t = 0; t < TRACKS; t++) begin
            s = mix_track_cfg[t];
            if (pcm_count[t] != 0) loaded = 1'b1;
            if (s[0] && !s[1]) begin
              vol = longint'(s[18:3]);
              if (vol > 32768) vol = 32768;
              pan    = longint'($signed(s[34:19]));
              rate   = 64'(s[51:35]);
              frames = s[2] ? 64'(pcm_count[t] >> 1) : 64'(pcm_count[t]);
              tf     = (64'(playhead) * rate) / 64'(OUT_RATE);
              if (tf < frames) begin
                active = 1'b1;
                if (s[2]) begin
                  sl = longint'(pcm_store[t][tf * 2]);
                  sr = longint'(pcm_store[t][tf * 2 + 1]);
                end else begin
                  sl = longint'(pcm_store[t][tf]);
                  sr = sl;
                end
                acc_l += sl * vol * (32768 - pan);
                acc_r += sr * vol * (32768 + pan);
              end
            end
          end
          mg = longint'(mix_master);
          ml = round_q(round_q(acc_l, 16) * mg, 29);
          mr = round_q(round_q(acc_r, 16) * mg, 29);
          if (ml != clip16(ml) || mr != clip16(mr)) clipped_frames++;
          if (playhead != PH_LIMIT) playhead++;
          // Playback ends once loaded material is exhausted past the start margin.
          if (!active && loaded && playhead > END_MARGIN) begin
            playing_now = 1'b0;
            playhead    = '0;
            stops_seen++;
          end
          fr.left_sample      = clip16(ml);
          fr.right_sample     = clip16(mr);
          fr.playing          = playing_now;
          fr.any_track_active = active;
        end
        frames_due.insert(frames_due.size(), fr);
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      calm_left = $urandom_range(8, 30);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic mtpm_in_t noise_item(input logic [2:0] cmd);
    logic [95:0] r;
    mtpm_in_t    it;
    r = {$urandom, $urandom, $urandom};
    it = r[$bits(mtpm_in_t)-1:0];
    it.command = cmd;
    return it;
  endfunction

  task automatic send_item(input mtpm_in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_payload <= it;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict(it);
    if (it.command <= CMD_CLEAR) items_sent++;
  endtask

  task automatic send_cmd(input logic [2:0] cmd);
    send_item(noise_item(cmd));
  endtask

  task automatic send_seek(input logic [30:0] frame);
    mtpm_in_t it;
    it = noise_item(CMD_SEEK);
    it.seek_frame = frame;
    send_item(it);
  endtask

  task automatic send_load(input int t, input int idx, input logic [15:0] val,
      input bit want_last);
    mtpm_in_t it;
    it = noise_item(CMD_LOAD);
    it.track        = 2'(t);
    it.sample_index = 16'(idx);
    it.sample_value = val;
    pcm_written[t][idx] = 1'b1;
    while (pcm_prefix[t] < MEM_DEPTH && pcm_written[t][pcm_prefix[t]]) pcm_prefix[t]++;
    // A track length may only cover loaded slots, so that no render reads empty memory.
    it.last_sample = want_last && (idx < pcm_prefix[t]);
    send_item(it);
  endtask

  task automatic drain(input int extra);
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic program_regs();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MASTER;
    cfg_wdata <= CFG_W'(next_master);
    @(posedge clk);
    mix_master = next_master;
    for (int t = 0; t < SETTING_REGS; t++) begin
      cfg_index <= CFG_MASTER + CFG_IDX_W'(t + 1);
      cfg_wdata <= next_track_cfg[t];
      @(posedge clk);
      mix_track_cfg[t] = next_track_cfg[t];
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_paused_render();
    send_cmd(CMD_RENDER);
    send_cmd(CMD_RSVD_LO);
    send_cmd(CMD_RSVD_HI);
    send_cmd(CMD_PAUSE);
    send_cmd(CMD_RENDER);
  endtask

  task automatic test_mix_extremes();
    drain(SETTLE_CYCLES);
    next_master       = 16'hFFFF;
    next_track_cfg[0] = pack_track(1'b1, 1'b0, 1'b0, 16'hFFFF, 16'h8000, 17'd48000);
    next_track_cfg[1] = pack_track(1'b1, 1'b0, 1'b1, 16'h8000, 16'h7FFF, 17'd96000);
    next_track_cfg[2] = pack_track(1'b1, 1'b1, 1'b0, 16'h8000, 16'h0000, 17'd48000);
    next_track_cfg[3] = pack_track(1'b1, 1'b0, 1'b0, 16'd20000, 16'h0000, 17'd0);
    program_regs();
    send_load(0, 0, 16'h8000, 1'b0);
    send_load(0, 1, 16'h7FFF, 1'b1);
    send_load(1, 0, 16'h7FFF, 1'b0);
    send_load(1, 1, 16'h8000, 1'b0);
    send_load(1, 2, 16'hFFFF, 1'b0);
    send_load(1, 3, 16'h0001, 1'b1);
    send_load(2, 0, 16'd12345, 1'b1);
    send_load(3, 0, 16'h7FFF, 1'b1);
    send_cmd(CMD_PLAY);
    repeat (3) send_cmd(CMD_RENDER);
  endtask

  task automatic test_end_of_play();
    drain(SETTLE_CYCLES);
    next_track_cfg[3] = pack_track(1'b0, 1'b0, 1'b0, 16'h8000, 16'h0000, 17'd0);
    program_regs();
    // Frame 100 keeps playing; the step to 101 with nothing in range stops it.
    send_seek(31'd99);
    repeat (3) send_cmd(CMD_RENDER);
    send_cmd(CMD_PLAY);
    send_cmd(CMD_RENDER);
  endtask

  task automatic test_playhead_limit();
    send_cmd(CMD_CLEAR);
    send_seek(PH_LIMIT);
    send_cmd(CMD_PLAY);
    repeat (2) send_cmd(CMD_RENDER);
    send_cmd(CMD_PAUSE);
  endtask

  task automatic test_random_mix();
    int          len, n, r, t, idx;
    logic [15:0] vol, pan;
    logic [16:0] rate;
    while (items_sent < ITEM_GOAL) begin
      drain(SETTLE_CYCLES);
      case ($urandom_range(0, 4))
        0:       next_master = 16'h0000;
        1:       next_master = 16'hFFFF;
        2:       next_master = MASTER_RESET;
        default: next_master = 16'($urandom);
      endcase
      for (int k = 0; k < SETTING_REGS; k++) begin
        case ($urandom_range(0, 3))
          0:       vol = 16'h0000;
          1:       vol = 16'h8000;
          2:       vol = 16'hFFFF;
          default: vol = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0:       pan = 16'h8000;
          1:       pan = 16'h7FFF;
          2:       pan = 16'h0000;
          default: pan = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
          0:       rate = 17'd0;
          1:       rate = 17'h1FFFF;
          2:       rate = 17'd96000;
          3:       rate = 17'd24000;
          4:       rate = 17'd44100;
          5:       rate = 17'($urandom);
          default: rate = 17'd48000;
        endcase
        next_track_cfg[k] = pack_track($urandom_range(0, 9) != 0, $urandom_range(0, 7) == 0,
            $urandom_range(0, 1) == 1, vol, pan, rate);
      end
      program_regs();

      if ($urandom_range(0, 1)) send_cmd(CMD_CLEAR);
      for (t = 0; t < TRACKS; t++) begin
        if ($urandom_range(0, 4) != 0) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
          for (idx = 0; idx < len; idx++) send_load(t, idx, 16'($urandom), idx == len - 1);
        end
      end
      send_seek(($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 12)));
      send_cmd(CMD_PLAY);

      n = $urandom_range(20, 60);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          if (!playing_now && r < 20) send_cmd(CMD_PLAY);
          else send_cmd(CMD_RENDER);
        end else if (r < 84) begin
          send_cmd(playing_now ? CMD_PAUSE : CMD_PLAY);
        end else if (r < 88) begin
          send_seek(($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 150)));
        end else if (r < 94) begin
          t   = $urandom_range(0, TRACKS - 1);
          idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MEM_DEPTH - 1)
                                            : $urandom_range(0, pcm_prefix[t] + 3);
          send_load(t, idx, 16'($urandom), $urandom_range(0, 1) == 1);
        end else if (r < 97) begin
          send_cmd($urandom_range(0, 1) ? CMD_RSVD_LO : CMD_RSVD_HI);
        end else if (r < 98) begin
          send_cmd(CMD_CLEAR);
        end else begin
          send_cmd(CMD_PLAY);
        end
      end
    end
  endtask

  // Receiver back-pressure: free runs, short stalls and the odd long one.
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(0, 8);
      end else if (r < 55) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(20, 60);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(15, 40);
      end
    end
  end

  always @(posedge clk) begin
    mtpm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $error("output transfer with no frame pending");
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        frames_checked++;
        if (out_payload.left_sample !== want.left_sample) begin
          $error("left_sample: expected %0d, got %0d", want.left_sample,
                 out_payload.left_sample);
          mismatches++;
        end
        if (out_payload.right_sample !== want.right_sample) begin
          $error("right_sample: expected %0d, got %0d", want.right_sample,
                 out_payload.right_sample);
          mismatches++;
        end
        if (out_payload.playing !== want.playing) begin
          $error("playing: expected %0b, got %0b", want.playing, out_payload.playing);
          mismatches++;
        end
        if (out_payload.any_track_active !== want.any_track_active) begin
          $error("any_track_active: expected %0b, got %0b", want.any_track_active,
                 out_payload.any_track_active);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_payload <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    mix_master  = MASTER_RESET;
    playhead    = '0;
    playing_now = 1'b0;
    for (int t = 0; t < TRACKS; t++) begin
      mix_track_cfg[t] = '0;
      pcm_count[t]     = '0;
      pcm_prefix[t]    = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_paused_render();
    test_mix_extremes();
    test_end_of_play();
    test_playhead_limit();
    test_random_mix();
    drain(SETTLE_CYCLES);

    $display("Sent %0d transfers in and checked %0d mixed frames, including %0d clipped frames",
             items_sent, frames_checked, clipped_frames);
    $display("and %0d stops at the end of loaded material.", stops_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d frames still pending.", frames_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mtpm_pkg.sv
rtl/multitrack_pan_mixer.sv
bench/multitrack_pan_mixer_tb.sv
